[design/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, codes and defaults for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int REGION_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF = 32;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam int REQ_W    = 13;
  localparam int ADDR_W   = 12;
  localparam int STATUS_W = 2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } ffa_status_t;

  typedef struct packed {
    logic              mode;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] free_address;
  } ffa_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   content_address;
    logic [STATUS_W-1:0] status;
  } ffa_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_NEXT,
    S_DECIDE,
    S_SHIFT,
    S_FIN,
    S_RES
  } ffa_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ALLOC,
    WR_FREE_SELF,
    WR_FREE_PREV
  } ffa_wr_t;

  typedef enum logic [2:0] {
    SH_NONE,
    SH_UP,
    SH_DN_NEXT,
    SH_DN_SELF,
    SH_DN_BOTH
  } ffa_shift_t;

  typedef struct packed {
    logic        load;
    logic        scan_start;
    logic        scan_rd;
    logic        track_prev;
    logic        hit;
    logic        cap_next;
    ffa_wr_t     wr_op;
    logic        sh_ld;
    ffa_shift_t  sh_set;
    logic        sh_rd;
    logic        finish;
    logic        code_ld;
    ffa_status_t code;
    logic        push;
  } ffa_cmd_t;

  typedef struct packed {
    logic mode;
    logic rvld;
    logic hit;
    logic last;
    logic split;
    logic cur_used;
    logic prev_free;
    logic next_free;
    logic sh_more;
    logic sh_busy;
    logic slot_free;
  } ffa_sts_t;

endpackage

[design/ffa_ram.sv]
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer: table scan, neighbor fetch, update, entry shift, result.
// ----------------------------------------------------------------------------
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd
);

  ffa_pkg::ffa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != ffa_pkg::S_IDLE);
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ffa_pkg::S_SCAN;
        end
      end
      ffa_pkg::S_SCAN: begin
        // reads run one entry ahead of the compare
        cmd.scan_rd = 1'b1;
        if (sts.rvld) begin
          if (sts.hit) begin
            cmd.hit   = 1'b1;
            state_nxt = ffa_pkg::S_NEXT;
          end else begin
            cmd.track_prev = 1'b1;
            if (sts.last) begin
              cmd.code_ld = 1'b1;
              cmd.code    = (sts.mode == ffa_pkg::MODE_FREE) ? ffa_pkg::ST_BADFREE
                                                             : ffa_pkg::ST_NOFIT;
              state_nxt   = ffa_pkg::S_RES;
            end
          end
        end
      end
      ffa_pkg::S_NEXT: begin
        cmd.cap_next = 1'b1;
        state_nxt    = ffa_pkg::S_DECIDE;
      end
      ffa_pkg::S_DECIDE: begin
        if (sts.mode == ffa_pkg::MODE_FREE && !sts.cur_used) begin
          cmd.code_ld = 1'b1;
          cmd.code    = ffa_pkg::ST_BADFREE;
          state_nxt   = ffa_pkg::S_RES;
        end else begin
          cmd.code_ld = 1'b1;
          cmd.code    = ffa_pkg::ST_OK;
          cmd.sh_ld   = 1'b1;
          state_nxt   = ffa_pkg::S_SHIFT;
          if (sts.mode == ffa_pkg::MODE_ALLOC) begin
            cmd.wr_op  = ffa_pkg::WR_ALLOC;
            cmd.sh_set = sts.split ? ffa_pkg::SH_UP : ffa_pkg::SH_NONE;
          end else if (sts.prev_free) begin
            cmd.wr_op  = ffa_pkg::WR_FREE_PREV;
            cmd.sh_set = sts.next_free ? ffa_pkg::SH_DN_BOTH : ffa_pkg::SH_DN_SELF;
          end else begin
            cmd.wr_op  = ffa_pkg::WR_FREE_SELF;
            cmd.sh_set = sts.next_free ? ffa_pkg::SH_DN_NEXT : ffa_pkg::SH_NONE;
          end
        end
      end
      ffa_pkg::S_SHIFT: begin
        cmd.sh_rd = sts.sh_more;
        if (!sts.sh_more && !sts.sh_busy) begin
          state_nxt = ffa_pkg::S_FIN;
        end
      end
      ffa_pkg::S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ffa_pkg::S_RES;
      end
      ffa_pkg::S_RES: begin
        if (sts.slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = ffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/ffa_dp.sv]
// ----------------------------------------------------------------------------
// ffa_dp
// Block table memory, scan compare, merge arithmetic, shifter and result reg.
// ----------------------------------------------------------------------------
module ffa_dp #(
  parameter int REGION_BYTES = ffa_pkg::REGION_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::ffa_in_t  in_data,
  input  ffa_pkg::ffa_cmd_t cmd,
  output ffa_pkg::ffa_sts_t sts,
  input  logic              out_stall,
  output logic              out_valid,
  output ffa_pkg::ffa_out_t out_data
);

  localparam int AW  = $clog2(REGION_BYTES);
  localparam int SW  = $clog2(REGION_BYTES + 1);
  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int CW  = $clog2(MAX_BLOCKS + 3);
  localparam int EW  = AW + SW + 1;
  localparam int MW  = ((SW > ffa_pkg::REQ_W) ? SW : ffa_pkg::REQ_W) + 2;

  localparam logic [MW-1:0] HDR      = MW'(HEADER_BYTES);
  localparam logic [MW-1:0] ADDR_LIM = MW'((1 << ffa_pkg::ADDR_W) - 1);
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_BLOCKS);
  localparam logic [EW-1:0] RST_ENTRY = {1'b0, SW'(REGION_BYTES - HEADER_BYTES), AW'(0)};

  ffa_pkg::ffa_in_t   req_r;
  logic [EW-1:0]      cur_r, prev_r, nxt_r;
  logic               nxt_vld_r;
  logic [IW-1:0]      idx_r, raddr_r;
  logic [CW-1:0]      count_r, rd_ptr_r, sp_r;
  logic               rvld_r, rsh_r, e0_init_r, rd0_r;
  ffa_pkg::ffa_shift_t sk_r;
  ffa_pkg::ffa_status_t code_r;
  logic               out_vld_r;
  ffa_pkg::ffa_out_t  out_r;

  logic               scan_go, sh_go, rd_en;
  logic [IW-1:0]      rd_addr;
  logic [EW-1:0]      ram_q, rdata;
  logic               wr_en, sh_wr;
  logic [IW-1:0]      wr_addr;
  logic [EW-1:0]      wr_data;

  logic [AW-1:0]      r_start, c_start, p_start;
  logic [SW-1:0]      r_size, c_size, p_size, n_size;
  logic               r_used, c_used, p_used, n_used;
  logic [MW-1:0]      req_ext, r_content, c_content, rest, nxt_term, self_sum, prev_sum;
  logic [CW-1:0]      cnt_m1, sh_dest;
  logic               split, next_free;

  assign r_start = rdata[AW-1:0];
  assign r_size  = rdata[AW+SW-1:AW];
  assign r_used  = rdata[EW-1];
  assign c_start = cur_r[AW-1:0];
  assign c_size  = cur_r[AW+SW-1:AW];
  assign c_used  = cur_r[EW-1];
  assign p_start = prev_r[AW-1:0];
  assign p_size  = prev_r[AW+SW-1:AW];
  assign p_used  = prev_r[EW-1];
  assign n_size  = nxt_r[AW+SW-1:AW];
  assign n_used  = nxt_r[EW-1];

  assign req_ext   = MW'(req_r.request_size);
  assign r_content = MW'(r_start) + HDR;
  assign c_content = MW'(c_start) + HDR;
  assign rest      = MW'(c_size) - req_ext;
  assign split     = (rest > HDR) && (count_r < MAX_CNT);
  assign next_free = nxt_vld_r && !n_used;
  assign nxt_term  = next_free ? (MW'(n_size) + HDR) : '0;
  assign self_sum  = MW'(c_size) + nxt_term;
  assign prev_sum  = MW'(p_size) + MW'(c_size) + HDR + nxt_term;
  assign cnt_m1    = count_r - CW'(1);

  // entry 0 holds the whole region until it is first written
  assign rdata = rd0_r ? RST_ENTRY : ram_q;

  assign scan_go = cmd.scan_rd && (rd_ptr_r < count_r);
  assign sh_go   = cmd.sh_rd;
  assign rd_en   = scan_go || sh_go;
  assign rd_addr = sh_go ? sp_r[IW-1:0] : rd_ptr_r[IW-1:0];

  assign sh_wr   = rvld_r && rsh_r;
  always_comb begin
    unique case (sk_r)
      ffa_pkg::SH_UP:      sh_dest = CW'(raddr_r) + CW'(1);
      ffa_pkg::SH_DN_BOTH: sh_dest = CW'(raddr_r) - CW'(2);
      default:             sh_dest = CW'(raddr_r) - CW'(1);
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = cur_r;
    priority if (sh_wr) begin
      wr_en   = 1'b1;
      wr_addr = sh_dest[IW-1:0];
      wr_data = rdata;
    end else if (cmd.wr_op == ffa_pkg::WR_ALLOC) begin
      wr_en   = 1'b1;
      wr_data = {1'b1, (split ? SW'(req_ext) : c_size), c_start};
    end else if (cmd.wr_op == ffa_pkg::WR_FREE_SELF) begin
      wr_en   = 1'b1;
      wr_data = {1'b0, SW'(self_sum), c_start};
    end else if (cmd.wr_op == ffa_pkg::WR_FREE_PREV) begin
      wr_en   = 1'b1;
      wr_addr = idx_r - IW'(1);
      wr_data = {1'b0, SW'(prev_sum), p_start};
    end else if (cmd.finish && sk_r == ffa_pkg::SH_UP) begin
      // split remainder goes in right after the allocated block
      wr_en   = 1'b1;
      wr_addr = idx_r + IW'(1);
      wr_data = {1'b0, SW'(rest - HDR), AW'(c_content + req_ext)};
    end
  end

  ffa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r    <= 1'b0;
      rsh_r     <= 1'b0;
      rd0_r     <= 1'b0;
      e0_init_r <= 1'b1;
      count_r   <= CW'(1);
      sk_r      <= ffa_pkg::SH_NONE;
      nxt_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rvld_r <= rd_en;
      rsh_r  <= sh_go;
      rd0_r  <= rd_en && (rd_addr == '0) && e0_init_r;
      if (wr_en && wr_addr == '0) begin
        e0_init_r <= 1'b0;
      end
      if (cmd.cap_next) begin
        nxt_vld_r <= rvld_r && !rsh_r;
      end
      if (cmd.sh_ld) begin
        sk_r <= cmd.sh_set;
      end
      if (cmd.finish) begin
        unique case (sk_r)
          ffa_pkg::SH_UP:      count_r <= count_r + CW'(1);
          ffa_pkg::SH_DN_NEXT,
          ffa_pkg::SH_DN_SELF: count_r <= count_r - CW'(1);
          ffa_pkg::SH_DN_BOTH: count_r <= count_r - CW'(2);
          default:             count_r <= count_r;
        endcase
      end
      if (cmd.push) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_r <= rd_addr;
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.scan_start) begin
      rd_ptr_r <= '0;
    end else if (scan_go) begin
      rd_ptr_r <= rd_ptr_r + CW'(1);
    end
    if (cmd.track_prev) begin
      prev_r <= rdata;
    end
    if (cmd.hit) begin
      cur_r <= rdata;
      idx_r <= raddr_r;
    end
    if (cmd.cap_next) begin
      nxt_r <= rdata;
    end
    if (cmd.sh_ld) begin
      unique case (cmd.sh_set)
        ffa_pkg::SH_UP:      sp_r <= cnt_m1;
        ffa_pkg::SH_DN_SELF: sp_r <= CW'(idx_r) + CW'(1);
        default:             sp_r <= CW'(idx_r) + CW'(2);
      endcase
    end else if (sh_go) begin
      sp_r <= (sk_r == ffa_pkg::SH_UP) ? sp_r - CW'(1) : sp_r + CW'(1);
    end
    if (cmd.code_ld) begin
      code_r <= cmd.code;
    end
    if (cmd.push) begin
      out_r.status          <= code_r;
      out_r.content_address <= (code_r == ffa_pkg::ST_OK && req_r.mode == ffa_pkg::MODE_ALLOC)
                               ? c_content[ffa_pkg::ADDR_W-1:0] : '0;
    end
  end

  always_comb begin
    sts.mode      = req_r.mode;
    sts.rvld      = rvld_r && !rsh_r;
    sts.last      = (CW'(raddr_r) == cnt_m1);
    sts.split     = split;
    sts.cur_used  = c_used;
    sts.prev_free = (idx_r != '0) && !p_used;
    sts.next_free = next_free;
    sts.sh_busy   = sh_wr;
    sts.slot_free = !out_vld_r || !out_stall;
    if (req_r.mode == ffa_pkg::MODE_ALLOC) begin
      sts.hit = !r_used && (MW'(r_size) >= req_ext);
    end else begin
      sts.hit = (r_content[ffa_pkg::ADDR_W-1:0] == req_r.free_address) &&
                (r_content <= ADDR_LIM);
    end
    unique case (sk_r)
      ffa_pkg::SH_NONE: sts.sh_more = 1'b0;
      ffa_pkg::SH_UP:   sts.sh_more = (sp_r != CW'(idx_r));
      default:          sts.sh_more = (sp_r < count_r);
    endcase
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= MAX_CNT))
    else $error("block count out of range");

  a_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    sh_wr |-> (cmd.wr_op == ffa_pkg::WR_NONE) && !cmd.finish)
    else $error("table update collides with shift write");

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_vld_r || !out_stall))
    else $error("result overwrites an item not yet taken");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && sk_r == ffa_pkg::SH_UP) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("split did not add a table entry");
`endif

endmodule

[design/first_fit_block_allocator.sv]
// Each request scans the table from entry 0 up to the matching entry,
// scanned one per cycle; a shift moves one entry per cycle. A miss scans all
// entries, and a free of a free block ends before any update or shift. One
// item in flight at a time.
// Reset: synchronous; table becomes one free block covering the region,
// result register empty. No clearing pass.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over an address-ordered block table with coalescing.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int REGION_BYTES = ffa_pkg::REGION_BYTES_DEF,
  parameter int HEADER_BYTES = ffa_pkg::HEADER_BYTES_DEF,
  parameter int MAX_BLOCKS   = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffa_pkg::ffa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ffa_pkg::ffa_out_t out_data
);

  ffa_pkg::ffa_cmd_t cmd;
  ffa_pkg::ffa_sts_t sts;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffa_dp #(
    .REGION_BYTES (REGION_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator testbench
// Drives allocate and free requests with random gaps and output stalls, keeps
// a model of the block table, and checks every result against it in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REGION = ffa_pkg::REGION_BYTES_DEF;
  localparam int HDR    = ffa_pkg::HEADER_BYTES_DEF;
  localparam int NBLK   = ffa_pkg::MAX_BLOCKS_DEF;
  localparam int REQ_W  = ffa_pkg::REQ_W;
  localparam int ADDR_W = ffa_pkg::ADDR_W;
  localparam int WATCHDOG_LIMIT = 20000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ffa_pkg::ffa_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  ffa_pkg::ffa_out_t out_data;

  first_fit_block_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // model of the block table
  int unsigned tbl_start [NBLK];
  int unsigned tbl_size  [NBLK];
  bit          tbl_used  [NBLK];
  int unsigned tbl_count;

  ffa_pkg::ffa_out_t alloc_results [$];
  int       fail_count = 0;
  int       idle_cycles = 0;
  int       out_wait = 0;
  bit       sending = 1'b0;

  task automatic table_reset();
    tbl_start[0] = 0;
    tbl_size[0]  = REGION - HDR;
    tbl_used[0]  = 1'b0;
    tbl_count    = 1;
  endtask

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_size[k]  = tbl_size[k+1];
      tbl_used[k]  = tbl_used[k+1];
    end
    tbl_count--;
  endfunction

  function automatic void absorb_following(int unsigned idx);
    while (idx + 1 < tbl_count && !tbl_used[idx+1]) begin
      tbl_size[idx] += tbl_size[idx+1] + HDR;
      drop_entry(idx + 1);
    end
  endfunction

  function automatic ffa_pkg::ffa_out_t allocate_or_free(ffa_pkg::ffa_in_t req);
    ffa_pkg::ffa_out_t res;
    int unsigned i;
    int unsigned rest;
    bit          found;
    res = '0;
    found = 1'b0;
    if (req.mode == ffa_pkg::MODE_ALLOC) begin
      for (i = 0; i < tbl_count; i++)
        if (!tbl_used[i] && tbl_size[i] >= req.request_size) begin
          found = 1'b1;
          break;
        end
      if (!found) begin
        res.status = ffa_pkg::ST_NOFIT;
      end else begin
        rest = tbl_size[i] - req.request_size;
        tbl_used[i] = 1'b1;
        if (rest > HDR && tbl_count < NBLK) begin
          tbl_size[i] = req.request_size;
          for (int unsigned k = tbl_count; k > i + 1; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k]  = tbl_size[k-1];
            tbl_used[k]  = tbl_used[k-1];
          end
          tbl_start[i+1] = tbl_start[i] + HDR + req.request_size;
          tbl_size[i+1]  = rest - HDR;
          tbl_used[i+1]  = 1'b0;
          tbl_count++;
          absorb_following(i + 1);
        end
        res.content_address = ADDR_W'(tbl_start[i] + HDR);
        res.status = ffa_pkg::ST_OK;
      end
    end else begin
      for (i = 0; i < tbl_count; i++)
        if (((tbl_start[i] + HDR) & 12'hFFF) == req.free_address &&
            tbl_start[i] + HDR <= 12'hFFF) begin
          found = 1'b1;
          break;
        end
      if (!found || !tbl_used[i]) begin
        res.status = ffa_pkg::ST_BADFREE;
      end else begin
        tbl_used[i] = 1'b0;
        absorb_following(i);
        if (i > 0 && !tbl_used[i-1]) absorb_following(i - 1);
        res.status = ffa_pkg::ST_OK;
      end
    end
    return res;
  endfunction

  // valid stays high across items sent with no gap
  task automatic send_item(ffa_pkg::ffa_in_t req);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    alloc_results.push_back(allocate_or_free(req));
  endtask

  // picks the content address of a used block, or a random one
  function automatic logic [ADDR_W-1:0] pick_used();
    int unsigned cand [$];
    for (int unsigned k = 0; k < tbl_count; k++)
      if (tbl_used[k]) cand.push_back(tbl_start[k] + HDR);
    if (cand.size() == 0) return ADDR_W'($urandom);
    return ADDR_W'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  function automatic ffa_pkg::ffa_in_t make_req(logic m, int unsigned sz, int unsigned fa);
    ffa_pkg::ffa_in_t r;
    r.mode = m;
    r.request_size = REQ_W'(sz);
    r.free_address = ADDR_W'(fa);
    return r;
  endfunction

  task automatic test_directed();
    send_item(make_req(ffa_pkg::MODE_FREE, $urandom, 32));      // free of free block
    send_item(make_req(ffa_pkg::MODE_ALLOC, 8191, 12'hFFF));    // oversized
    send_item(make_req(ffa_pkg::MODE_ALLOC, REGION - HDR + 1, 0));
    send_item(make_req(ffa_pkg::MODE_ALLOC, 0, 0));             // zero size
    send_item(make_req(ffa_pkg::MODE_ALLOC, 100, 0));
    send_item(make_req(ffa_pkg::MODE_ALLOC, 30, 0));
    send_item(make_req(ffa_pkg::MODE_ALLOC, 200, 0));
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 33));             // not a block
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 64));             // middle block
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 196));            // merge with previous block
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 32));
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 32));             // double free
    send_item(make_req(ffa_pkg::MODE_ALLOC, REGION - HDR, 0));  // whole region
    send_item(make_req(ffa_pkg::MODE_ALLOC, 0, 0));
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 32));
    send_item(make_req(ffa_pkg::MODE_ALLOC, REGION - 2 * HDR - 10, 0)); // does not fit
    send_item(make_req(ffa_pkg::MODE_FREE, 0, 32));
    send_item(make_req(ffa_pkg::MODE_FREE, $urandom, 12'hFFF));
  endtask

  // fill the table past its capacity with small blocks, then release them
  task automatic test_table_full();
    for (int n = 0; n < 70; n++)
      send_item(make_req(ffa_pkg::MODE_ALLOC, $urandom_range(0, 40), $urandom));
    for (int n = 0; n < 70; n++)
      send_item(make_req(ffa_pkg::MODE_FREE, $urandom, pick_used()));
  endtask

  task automatic test_random(int n_items);
    ffa_pkg::ffa_in_t r;
    for (int n = 0; n < n_items; n++) begin
      r.mode         = 1'($urandom_range(0, 1));
      r.request_size = REQ_W'($urandom);
      r.free_address = ADDR_W'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          r.mode = ffa_pkg::MODE_ALLOC;
          r.request_size = $urandom_range(0, 9) == 0 ? REQ_W'($urandom)
                                                     : REQ_W'($urandom_range(0, 300));
        end
        4, 5, 6, 7: begin
          r.mode = ffa_pkg::MODE_FREE;
          r.free_address = pick_used();
        end
        default: ;
      endcase
      send_item(r);
    end
  endtask

  // result checker; the output side stalls at random after each item it takes
  always @(posedge clk) begin
    ffa_pkg::ffa_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (alloc_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
        fail_count++;
      end else begin
        want = alloc_results.pop_front();
        if (out_data.content_address !== want.content_address) begin
          $display("%0t content_address mismatch: expected %h actual %h",
                   $time, want.content_address, out_data.content_address);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, want.status, out_data.status);
          fail_count++;
        end
      end
      out_wait = $urandom_range(0, 15);
    end else if (out_wait > 0) begin
      out_wait--;
    end
    out_stall <= (out_wait != 0);
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    table_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random(1500);
    in_valid <= 1'b0;
    while (alloc_results.size() != 0) @(posedge clk);
    repeat (2 * NBLK + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[files.f]
design/ffa_pkg.sv
design/ffa_ram.sv
design/ffa_ctrl.sv
design/ffa_dp.sv
design/first_fit_block_allocator.sv
test/testbench.sv
